// ----- hdl/vdma_pkg.sv -----
// vdma_pkg: types, register indexes and constants for the VRAM DMA engine.
// No dependencies; used by every module under hdl.
package vdma_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam logic [2:0] CFG_SOURCE_HIGH  = 3'd0;
  localparam logic [2:0] CFG_SOURCE_LOW   = 3'd1;
  localparam logic [2:0] CFG_DEST_HIGH    = 3'd2;
  localparam logic [2:0] CFG_DEST_LOW     = 3'd3;
  localparam logic [2:0] CFG_SPEED_FACTOR = 3'd4;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [7:0]  ADDR_LOW_MASK = 8'b1111_0000;
  localparam logic [7:0]  DEST_HI_MASK  = 8'b0001_1111;
  localparam logic [7:0]  LEN_MASK      = 8'b0111_1111;
  localparam logic [7:0]  HBLANK_BIT    = 8'b1000_0000;
  localparam logic [7:0]  STATUS_DONE   = 8'hFF;
  localparam logic [15:0] VRAM_BASE     = 16'h8000;
  localparam logic [15:0] EXT_RAM_BASE  = 16'hA000;
  localparam logic [15:0] ECHO_BASE     = 16'hE000;
  localparam logic [13:0] SETUP_CYCLES  = 14'd4;
  localparam logic [13:0] CYCLE_MAX     = 14'h3FFF;
  localparam logic [4:0]  HBLANK_BURST  = 5'd16;
  localparam logic [1:0]  SPEED_RESET   = 2'd1;

  typedef struct packed {
    logic [7:0] source_high;
    logic [7:0] source_low;
    logic [7:0] dest_high;
    logic [7:0] dest_low;
    logic [1:0] speed_factor;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] control_value;
    logic [7:0] consumed_cycles;
    logic       in_hblank;
  } item_t;

  typedef struct packed {
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic [11:0] copy_length;
    logic [7:0]  status_value;
    logic        busy_res;
  } res_t;

endpackage

// ----- hdl/vram_dma_general_hblank.sv -----
// VRAM DMA engine, top level: item register, core, result register.
// An input item is held in the item register and then, once the output is free,
// captured into the result register, which raises out_valid.
// Throughput: one item per cycle; in_ready drops only while a result waits
// at the output and the item register is full.
// Reset (rst, synchronous): clears transfer state and both handshake stages.
module vram_dma_general_hblank (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  control_value,
  input  logic [7:0]  consumed_cycles,
  input  logic        in_hblank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        copy_valid,
  output logic [15:0] copy_source,
  output logic [15:0] copy_dest,
  output logic [11:0] copy_length,
  output logic [7:0]  status_value,
  output logic        busy_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  vdma_pkg::cfg_t  cfg;
  vdma_pkg::item_t item_q;
  vdma_pkg::res_t  res;
  vdma_pkg::res_t  res_q;
  logic            item_valid;
  logic            go;

  assign cfg_ready = 1'b1;
  assign go        = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || go;

  vdma_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vdma_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= '{operation: operation, control_value: control_value,
                  consumed_cycles: consumed_cycles, in_hblank: in_hblank};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_q <= res;
    end
  end

  assign copy_valid   = res_q.copy_valid;
  assign copy_source  = res_q.copy_source;
  assign copy_dest    = res_q.copy_dest;
  assign copy_length  = res_q.copy_length;
  assign status_value = res_q.status_value;
  assign busy_res     = res_q.busy_res;

endmodule

// ----- hdl/vdma_cfg.sv -----
// vdma_cfg: source, destination and speed registers behind the write channel.
// Depends on vdma_pkg.
module vdma_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [7:0]        wr_data,
  output vdma_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_high  <= '0;
      cfg.source_low   <= '0;
      cfg.dest_high    <= '0;
      cfg.dest_low     <= '0;
      cfg.speed_factor <= vdma_pkg::SPEED_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        vdma_pkg::CFG_SOURCE_HIGH:  cfg.source_high  <= wr_data;
        vdma_pkg::CFG_SOURCE_LOW:   cfg.source_low   <= wr_data;
        vdma_pkg::CFG_DEST_HIGH:    cfg.dest_high    <= wr_data;
        vdma_pkg::CFG_DEST_LOW:     cfg.dest_low     <= wr_data;
        vdma_pkg::CFG_SPEED_FACTOR: cfg.speed_factor <= wr_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/vdma_core.sv -----
// vdma_core: transfer state and the one-pass next-state and result logic.
// Depends on vdma_pkg; driven by the item register in the top level.
module vdma_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  vdma_pkg::item_t   item,
  input  vdma_pkg::cfg_t    cfg,
  output vdma_pkg::res_t    res
);

  logic        active, active_next;
  logic        request_pending, request_pending_next;
  logic        hblank_mode, hblank_mode_next;
  logic [7:0]  control_byte, control_byte_next;
  logic [15:0] current_source, current_source_next;
  logic [15:0] current_dest, current_dest_next;
  logic [11:0] bytes_left, bytes_left_next;
  logic [4:0]  bytes_this_hblank, bytes_this_hblank_next;
  logic [13:0] cycles_elapsed, cycles_elapsed_next;
  logic [13:0] cycles_needed, cycles_needed_next;

  logic [15:0] load_src;
  logic [15:0] load_dst;
  logic        src_ok;
  logic [11:0] load_len;
  logic [13:0] load_prod;
  logic [13:0] load_needed;

  // transfer set-up values from the registers and the stored control byte
  always_comb begin
    load_src    = {cfg.source_high, cfg.source_low & vdma_pkg::ADDR_LOW_MASK};
    load_dst    = {cfg.dest_high & vdma_pkg::DEST_HI_MASK,
                   cfg.dest_low & vdma_pkg::ADDR_LOW_MASK} | vdma_pkg::VRAM_BASE;
    src_ok      = (load_src < vdma_pkg::VRAM_BASE) ||
                  ((load_src >= vdma_pkg::EXT_RAM_BASE) && (load_src < vdma_pkg::ECHO_BASE));
    load_len    = 12'({1'b0, control_byte & vdma_pkg::LEN_MASK} + 9'd1)
                  << vdma_pkg::BLOCK_SHIFT;
    load_prod   = 14'(load_len) * 14'(cfg.speed_factor);
    load_needed = vdma_pkg::SETUP_CYCLES + (load_prod << 1);
  end

  always_comb begin
    logic        do_load;
    logic        run;
    logic [14:0] csum;

    active_next            = active;
    request_pending_next   = request_pending;
    hblank_mode_next       = hblank_mode;
    control_byte_next      = control_byte;
    current_source_next    = current_source;
    current_dest_next      = current_dest;
    bytes_left_next        = bytes_left;
    bytes_this_hblank_next = bytes_this_hblank;
    cycles_elapsed_next    = cycles_elapsed;
    cycles_needed_next     = cycles_needed;
    do_load                = 1'b0;
    run                    = 1'b0;
    csum                   = '0;

    res.copy_valid  = 1'b0;
    res.copy_source = '0;
    res.copy_dest   = '0;
    res.copy_length = '0;

    if (item.operation == vdma_pkg::OP_WRITE) begin
      control_byte_next    = item.control_value;
      request_pending_next = 1'b1;
    end else begin
      if (!active) begin
        do_load = request_pending;
      end else if (hblank_mode && request_pending) begin
        if ((control_byte & vdma_pkg::HBLANK_BIT) == 8'd0) begin
          request_pending_next = 1'b0;
          active_next          = 1'b0;
          control_byte_next    = control_byte | vdma_pkg::HBLANK_BIT;
        end else begin
          do_load = 1'b1;
        end
      end

      if (do_load) begin
        request_pending_next = 1'b0;
        if (src_ok) begin
          current_source_next    = load_src;
          current_dest_next      = load_dst;
          hblank_mode_next       = control_byte[7];
          bytes_left_next        = load_len;
          cycles_needed_next     = load_needed;
          bytes_this_hblank_next = '0;
          cycles_elapsed_next    = '0;
          active_next            = 1'b1;
        end
      end

      if (hblank_mode_next && active_next) begin
        if (item.in_hblank) begin
          run = (bytes_left_next != 12'd0) && (bytes_this_hblank_next < vdma_pkg::HBLANK_BURST);
        end else begin
          bytes_this_hblank_next = '0;
        end
      end else begin
        run = active_next;
      end

      if (run) begin
        if (!hblank_mode_next) begin
          csum = {1'b0, cycles_elapsed_next} + 15'(item.consumed_cycles);
          cycles_elapsed_next = csum[14] ? vdma_pkg::CYCLE_MAX : csum[13:0];
          if (cycles_elapsed_next >= cycles_needed_next) begin
            active_next     = 1'b0;
            res.copy_valid  = 1'b1;
            res.copy_source = current_source_next;
            res.copy_dest   = current_dest_next;
            res.copy_length = bytes_left_next;
          end
        end else begin
          res.copy_valid         = 1'b1;
          res.copy_source        = current_source_next;
          res.copy_dest          = current_dest_next;
          res.copy_length        = 12'd1;
          bytes_this_hblank_next = bytes_this_hblank_next + 5'd1;
          bytes_left_next        = bytes_left_next - 12'd1;
          current_source_next    = current_source_next + 16'd1;
          current_dest_next      = current_dest_next + 16'd1;
          if (bytes_left_next == 12'd0) begin
            control_byte_next = vdma_pkg::STATUS_DONE;
            active_next       = 1'b0;
          end else begin
            control_byte_next = vdma_pkg::HBLANK_BIT |
                                (bytes_left_next[11:4] - 8'd1);
          end
        end
      end
    end

    res.status_value = control_byte_next;
    res.busy_res     = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      request_pending   <= 1'b0;
      hblank_mode       <= 1'b0;
      control_byte      <= '0;
      current_source    <= '0;
      current_dest      <= '0;
      bytes_left        <= '0;
      bytes_this_hblank <= '0;
      cycles_elapsed    <= '0;
      cycles_needed     <= '0;
    end else if (go) begin
      active            <= active_next;
      request_pending   <= request_pending_next;
      hblank_mode       <= hblank_mode_next;
      control_byte      <= control_byte_next;
      current_source    <= current_source_next;
      current_dest      <= current_dest_next;
      bytes_left        <= bytes_left_next;
      bytes_this_hblank <= bytes_this_hblank_next;
      cycles_elapsed    <= cycles_elapsed_next;
      cycles_needed     <= cycles_needed_next;
    end
  end

`ifndef ASSERT_OFF
  a_write_marks_request: assert property (@(posedge clk) disable iff (rst)
    go && (item.operation == vdma_pkg::OP_WRITE) |=> request_pending)
    else $error("control write did not leave a request pending");

  a_burst_limit: assert property (@(posedge clk) disable iff (rst)
    bytes_this_hblank <= vdma_pkg::HBLANK_BURST)
    else $error("HBLANK burst count beyond limit");

  a_hblank_has_bytes: assert property (@(posedge clk) disable iff (rst)
    active && hblank_mode |-> bytes_left != 12'd0)
    else $error("active HBLANK transfer with no bytes left");

  a_block_copy_ends: assert property (@(posedge clk) disable iff (rst)
    go && res.copy_valid && (res.copy_length != 12'd1) |=> !active)
    else $error("general transfer still busy after its block copy");
`endif

endmodule

// ----- tb/vdma_copy_checker.sv -----
// vdma_copy_checker: follows the item, result and register channels of the VRAM
// DMA engine, predicts every result and compares it with what the engine returns.
// Depends on vdma_pkg.
module vdma_copy_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  control_value,
  input  logic [7:0]  consumed_cycles,
  input  logic        in_hblank,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        copy_valid,
  input  logic [15:0] copy_source,
  input  logic [15:0] copy_dest,
  input  logic [11:0] copy_length,
  input  logic [7:0]  status_value,
  input  logic        busy_res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          due
);

  vdma_pkg::cfg_t  regs;
  logic            running, req_waiting, hb_mode;
  logic [7:0]      ctrl;
  logic [15:0]     src_ptr, dst_ptr;
  logic [11:0]     bytes_to_go;
  logic [4:0]      burst_bytes;
  logic [13:0]     cycles_seen, cycles_due;
  vdma_pkg::res_t  copy_cmds_due[$];
  vdma_pkg::res_t  want, seen;
  vdma_pkg::item_t taken;

  // Set-up from the registers; a source outside 0x0000-0x7FFF and 0xA000-0xDFFF is dropped.
  function automatic void take_request();
    logic [15:0] src;
    int unsigned len, need;
    req_waiting = 1'b0;
    src = {regs.source_high, regs.source_low & vdma_pkg::ADDR_LOW_MASK};
    if (src < vdma_pkg::VRAM_BASE ||
        (src >= vdma_pkg::EXT_RAM_BASE && src < vdma_pkg::ECHO_BASE)) begin
      src_ptr = src;
      dst_ptr = {regs.dest_high & vdma_pkg::DEST_HI_MASK,
                 regs.dest_low & vdma_pkg::ADDR_LOW_MASK} | vdma_pkg::VRAM_BASE;
      hb_mode = (ctrl & vdma_pkg::HBLANK_BIT) != 0;
      len = (int'(ctrl & vdma_pkg::LEN_MASK) + 1) * vdma_pkg::BLOCK_BYTES;
      bytes_to_go = len[11:0];
      need = vdma_pkg::SETUP_CYCLES + len * 2 * regs.speed_factor;
      cycles_due = need[13:0];
      burst_bytes = '0;
      cycles_seen = '0;
      running = 1'b1;
    end
  endfunction

  function automatic vdma_pkg::res_t next_copy_cmd(vdma_pkg::item_t it);
    vdma_pkg::res_t r;
    logic go;
    int unsigned sum;
    int blocks_left;
    r = '0;
    if (it.operation == vdma_pkg::OP_WRITE) begin
      ctrl = it.control_value;
      req_waiting = 1'b1;
    end else begin
      if (!running) begin
        if (req_waiting) take_request();
      end else if (hb_mode && req_waiting) begin
        if ((ctrl & vdma_pkg::HBLANK_BIT) == 0) begin
          req_waiting = 1'b0;
          running = 1'b0;
          ctrl = ctrl | vdma_pkg::HBLANK_BIT;
        end else begin
          take_request();
        end
      end
      if (hb_mode && running) begin
        if (it.in_hblank) begin
          go = bytes_to_go != 0 && burst_bytes < vdma_pkg::HBLANK_BURST;
        end else begin
          burst_bytes = '0;
          go = 1'b0;
        end
      end else begin
        go = running;
      end
      if (go && !hb_mode) begin
        sum = cycles_seen + it.consumed_cycles;
        cycles_seen = (sum > vdma_pkg::CYCLE_MAX) ? vdma_pkg::CYCLE_MAX : sum[13:0];
        if (cycles_seen >= cycles_due) begin
          running = 1'b0;
          r.copy_valid = 1'b1;
          r.copy_source = src_ptr;
          r.copy_dest = dst_ptr;
          r.copy_length = bytes_to_go;
        end
      end else if (go) begin
        r.copy_valid = 1'b1;
        r.copy_source = src_ptr;
        r.copy_dest = dst_ptr;
        r.copy_length = 12'd1;
        burst_bytes = burst_bytes + 5'd1;
        bytes_to_go = bytes_to_go - 12'd1;
        src_ptr = src_ptr + 16'd1;
        dst_ptr = dst_ptr + 16'd1;
        if (bytes_to_go == 0) begin
          ctrl = vdma_pkg::STATUS_DONE;
          running = 1'b0;
        end else begin
          blocks_left = int'(bytes_to_go >> vdma_pkg::BLOCK_SHIFT) - 1;
          ctrl = vdma_pkg::HBLANK_BIT | blocks_left[7:0];
        end
      end
    end
    r.status_value = ctrl;
    r.busy_res = running;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = '0;
      regs.speed_factor = vdma_pkg::SPEED_RESET;
      running = 1'b0;
      req_waiting = 1'b0;
      hb_mode = 1'b0;
      ctrl = '0;
      src_ptr = '0;
      dst_ptr = '0;
      bytes_to_go = '0;
      burst_bytes = '0;
      cycles_seen = '0;
      cycles_due = '0;
      copy_cmds_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vdma_pkg::CFG_SOURCE_HIGH:  regs.source_high = cfg_data;
          vdma_pkg::CFG_SOURCE_LOW:   regs.source_low = cfg_data;
          vdma_pkg::CFG_DEST_HIGH:    regs.dest_high = cfg_data;
          vdma_pkg::CFG_DEST_LOW:     regs.dest_low = cfg_data;
          vdma_pkg::CFG_SPEED_FACTOR: regs.speed_factor = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = {copy_valid, copy_source, copy_dest, copy_length, status_value, busy_res};
        if (copy_cmds_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result with none pending: v=%b src=%h dst=%h len=%0d st=%h busy=%b",
                     seen.copy_valid, seen.copy_source, seen.copy_dest, seen.copy_length,
                     seen.status_value, seen.busy_res);
        end else begin
          want = copy_cmds_due.pop_front();
          if (seen.copy_valid !== want.copy_valid || seen.copy_source !== want.copy_source ||
              seen.copy_dest !== want.copy_dest || seen.copy_length !== want.copy_length ||
              seen.status_value !== want.status_value || seen.busy_res !== want.busy_res) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result mismatch: expected v=%b src=%h dst=%h len=%0d st=%h busy=%b,",
                        " got v=%b src=%h dst=%h len=%0d st=%h busy=%b"},
                       want.copy_valid, want.copy_source, want.copy_dest, want.copy_length,
                       want.status_value, want.busy_res,
                       seen.copy_valid, seen.copy_source, seen.copy_dest, seen.copy_length,
                       seen.status_value, seen.busy_res);
          end
        end
      end
      if (in_valid && in_ready) begin
        taken.operation = operation;
        taken.control_value = control_value;
        taken.consumed_cycles = consumed_cycles;
        taken.in_hblank = in_hblank;
        copy_cmds_due.push_back(next_copy_cmd(taken));
      end
    end
    due = copy_cmds_due.size();
  end

endmodule

// ----- tb/tb_vram_dma_general_hblank.sv -----
// tb_vram_dma_general_hblank: stimulus and verdict for the VRAM DMA engine.
// Directed general/HBLANK transfers, then random transfer bursts over many settings.
// Depends on vdma_pkg, the engine and vdma_copy_checker.
module tb_vram_dma_general_hblank;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic        operation;
  logic [7:0]  control_value, consumed_cycles;
  logic        in_hblank;
  logic        out_valid, out_ready;
  logic        copy_valid;
  logic [15:0] copy_source, copy_dest;
  logic [11:0] copy_length;
  logic [7:0]  status_value;
  logic        busy_res;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fail_count, due;
  int          items_sent;
  logic        calm, hold_req;
  logic [1:0]  cur_speed;

  vram_dma_general_hblank i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .control_value(control_value),
    .consumed_cycles(consumed_cycles), .in_hblank(in_hblank),
    .out_valid(out_valid), .out_ready(out_ready),
    .copy_valid(copy_valid), .copy_source(copy_source), .copy_dest(copy_dest),
    .copy_length(copy_length), .status_value(status_value), .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vdma_copy_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .control_value(control_value),
    .consumed_cycles(consumed_cycles), .in_hblank(in_hblank),
    .out_valid(out_valid), .out_ready(out_ready),
    .copy_valid(copy_valid), .copy_source(copy_source), .copy_dest(copy_dest),
    .copy_length(copy_length), .status_value(status_value), .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .due(due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send(input logic op, input logic [7:0] cv, input logic [7:0] cc,
                      input logic hb);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    control_value = cv;
    consumed_cycles = cc;
    in_hblank = hb;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic tick(input logic [7:0] cc, input logic hb);
    send(vdma_pkg::OP_TICK, 8'($urandom), cc, hb);
  endtask

  task automatic ctrl_write(input logic [7:0] cv);
    send(vdma_pkg::OP_WRITE, cv, 8'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // only between phases, with every result back
  task automatic load_regs(input logic [7:0] sh, input logic [7:0] sl,
                           input logic [7:0] dh, input logic [7:0] dl,
                           input logic [1:0] sp);
    in_valid = 1'b0;
    while (due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(vdma_pkg::CFG_SOURCE_HIGH, sh);
    write_reg(vdma_pkg::CFG_SOURCE_LOW, sl);
    write_reg(vdma_pkg::CFG_DEST_HIGH, dh);
    write_reg(vdma_pkg::CFG_DEST_LOW, dl);
    write_reg(vdma_pkg::CFG_SPEED_FACTOR, {6'd0, sp});
    cur_speed = sp;
  endtask

  task automatic general_copy(input logic [6:0] blocks);
    int need, got, n;
    logic [7:0] cc;
    need = 4 + (int'(blocks) + 1) * 16 * 2 * int'(cur_speed);
    got = 0;
    n = 0;
    ctrl_write({1'b0, blocks});
    while (got < need && n < 120) begin
      if ($urandom_range(39) == 0) begin
        ctrl_write(8'($urandom));
      end else begin
        cc = 8'($urandom);
        tick(cc, 1'($urandom));
        got += cc;
      end
      n++;
    end
  endtask

  task automatic hblank_copy(input logic [6:0] blocks);
    int left, n;
    logic [4:0] burst;
    left = (int'(blocks) + 1) * 16;
    n = 0;
    ctrl_write({1'b1, blocks});
    while (left > 0 && n < 300) begin
      burst = '0;
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(59) == 0) begin
          ctrl_write(8'($urandom));
        end else begin
          tick(8'($urandom), 1'b1);
          if (burst < 16 && left > 0) begin
            left--;
            burst++;
          end
        end
        n++;
      end
      repeat ($urandom_range(1, 3)) tick(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        held = 1'b1;
      end
      out_ready = calm || ($urandom_range(99) >= 37);
    end
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int phase, k, guard;
    logic [7:0] sh;
    logic [6:0] blocks;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = vdma_pkg::OP_TICK;
    control_value = '0;
    consumed_cycles = '0;
    in_hblank = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = vdma_pkg::CFG_SOURCE_HIGH;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    cur_speed = vdma_pkg::SPEED_RESET;
    items_sent = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // reset registers: ROM source at 0, destination 0x8000, normal speed
    tick(8'd0, 1'b0);
    ctrl_write(8'h00);
    tick(8'd0, 1'b1);
    ctrl_write(8'h81);           // held back until the general transfer is done
    tick(8'd255, 1'b0);
    tick(8'd7, 1'b1);
    repeat (2) tick(8'd0, 1'b1);
    tick(8'd0, 1'b0);
    ctrl_write(8'h05);           // cancel
    tick(8'd0, 1'b1);
    ctrl_write(8'h81);
    tick(8'd0, 1'b1);
    ctrl_write(8'h83);           // restart
    tick(8'd0, 1'b1);
    load_regs(8'h80, 8'h00, 8'h00, 8'h00, 2'd1);   // VRAM source, dropped
    ctrl_write(8'h80);
    tick(8'd0, 1'b1);
    load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
    ctrl_write(8'hFF);
    tick(8'd255, 1'b1);
    load_regs(8'hDF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
    ctrl_write(8'hFF);
    tick(8'd255, 1'b1);
    tick(8'd0, 1'b1);
    ctrl_write(8'h7F);
    tick(8'd255, 1'b0);
    load_regs(8'h00, 8'h0F, 8'h00, 8'h0F, 2'd0);
    ctrl_write(8'h00);
    tick(8'd3, 1'b0);
    tick(8'd1, 1'b0);

    phase = 0;
    while (items_sent < 1850) begin
      k = $urandom_range(9);
      if (k == 0) sh = 8'($urandom_range(8'h80, 8'h9F));
      else if (k == 1) sh = 8'($urandom_range(8'hE0, 8'hFF));
      else if (k < 6) sh = 8'($urandom_range(8'h00, 8'h7F));
      else sh = 8'($urandom_range(8'hA0, 8'hDF));
      k = $urandom_range(9);
      load_regs(sh, 8'($urandom), 8'($urandom), 8'($urandom),
                (k == 0) ? 2'd0 : (k == 1) ? 2'd3 : (k < 6) ? 2'd1 : 2'd2);
      calm = (phase == 2);
      if (phase == 4) hold_req = 1'b1;
      repeat (6) begin
        if (items_sent < 1850) begin
          k = $urandom_range(9);
          blocks = 7'(($urandom_range(24) == 0) ? $urandom_range(127) : $urandom_range(3));
          if (k == 0) begin
            repeat ($urandom_range(1, 8))
              send(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
          end else if (k < 5) begin
            general_copy(blocks);
          end else begin
            hblank_copy(blocks);
          end
        end
      end
      phase++;
    end

    in_valid = 1'b0;
    guard = 0;
    while (due != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && due == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
